[hw/rtl/cdnt_pkg.sv]
// Shared types and codes for the conditional directive nesting tracker.
`default_nettype none
package cdnt_pkg;

    localparam int REQ_W    = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 5;
    localparam int OPEN_W   = 6;

    typedef enum logic [REQ_W-1:0] {
        REQ_IF    = 3'd0,
        REQ_ELIF  = 3'd1,
        REQ_ELSE  = 3'd2,
        REQ_ENDIF = 3'd3,
        REQ_EOF   = 3'd4
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 3'd0,
        ST_LONE_ELIF     = 3'd1,
        ST_LONE_ELSE     = 3'd2,
        ST_LONE_ENDIF    = 3'd3,
        ST_MALFORMED     = 3'd4,
        ST_TOO_DEEP      = 3'd5,
        ST_OPEN_AT_END   = 3'd6,
        ST_SKIP_OVERFLOW = 3'd7
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } cell_op_t;

endpackage
`default_nettype wire

[hw/rtl/conditional_directive_nesting_tracker.sv]
// Top level: directive decode, nesting counters, stack cell row and output register.
// The result word is registered and appears in the cycle after its directive is accepted.
// Throughput: one directive per cycle unless m_tready holds the output; the output
// register lets a new word in while the previous result is taken in the same cycle.
// Reset (aresetn low, synchronous): depth, skip counter, skip flag and output
// valid clear; stack cells hold no reset and are written before being read.
`default_nettype none
module conditional_directive_nesting_tracker
    import cdnt_pkg::*;
#(
    parameter int MAX_NEST = 30
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [0] cond_value, [1] cond_malformed
    input  wire logic [2:0]  s_tuser,  // [2:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata   // [0] skip_lines, [3:1] status,
                                       // [8:4] nest_depth, [14:9] open_count
);

    localparam int DW = $clog2(MAX_NEST + 1);
    localparam int SW = DW + 1;

    logic [DW-1:0] depth_reg, depth_next;
    logic [DW-1:0] skipped_reg, skipped_next;
    logic          skip_reg, skip_next;
    logic          m_valid_reg, m_valid_next;
    logic [15:0]   m_data_reg, m_data_next;

    logic          accept;
    req_t          req;
    logic          cond;
    logic          bad;
    status_t       status;
    logic [SW-1:0] open_sum;
    logic [SW+OPEN_W-1:0] open_ext;
    logic [DW+DEPTH_W-1:0] depth_ext;
    logic          top_val;
    logic          cell0_in;
    cell_op_t      op;
    cell_op_t      cell_ops [MAX_NEST];
    logic          vals [MAX_NEST];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign req      = req_t'(s_tuser);
    assign cond     = s_tdata[0];
    assign bad      = s_tdata[1];
    assign top_val  = vals[0];

    always_comb begin
        depth_next   = depth_reg;
        skipped_next = skipped_reg;
        skip_next    = skip_reg;
        status       = ST_OK;
        open_sum     = '0;
        op           = '0;
        cell0_in     = cond;
        unique case (req)
            REQ_IF: begin
                if (skip_reg) begin
                    if (skipped_reg < DW'(MAX_NEST)) begin
                        skipped_next = skipped_reg + 1'b1;
                    end else begin
                        status = ST_SKIP_OVERFLOW;
                    end
                end else if (bad) begin
                    status = ST_MALFORMED;
                end else if (depth_reg >= DW'(MAX_NEST)) begin
                    status = ST_TOO_DEEP;
                end else begin
                    op.push    = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    skip_next  = !cond;
                end
            end
            REQ_ELIF: begin
                if (depth_reg == '0) begin
                    status = ST_LONE_ELIF;
                end else if (skipped_reg != '0) begin
                    status = ST_OK;
                end else if (bad) begin
                    status = ST_MALFORMED;
                end else if (top_val) begin
                    skip_next = 1'b1;
                end else begin
                    op.load   = 1'b1;
                    skip_next = !cond;
                end
            end
            REQ_ELSE: begin
                cell0_in = 1'b1;
                if (depth_reg == '0) begin
                    status = ST_LONE_ELSE;
                end else if (skipped_reg != '0) begin
                    status = ST_OK;
                end else if (top_val) begin
                    skip_next = 1'b1;
                end else begin
                    op.load   = 1'b1;
                    skip_next = 1'b0;
                end
            end
            REQ_ENDIF: begin
                if (skipped_reg != '0) begin
                    skipped_next = skipped_reg - 1'b1;
                end else if (depth_reg == '0) begin
                    status = ST_LONE_ENDIF;
                end else begin
                    op.pop     = 1'b1;
                    skip_next  = 1'b0;
                    depth_next = depth_reg - 1'b1;
                end
            end
            REQ_EOF: begin
                open_sum = SW'(depth_reg) + SW'(skipped_reg);
                if (depth_reg != '0) begin
                    status = ST_OPEN_AT_END;
                end
                depth_next   = '0;
                skipped_next = '0;
                skip_next    = 1'b0;
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (!accept) begin
            op = '0;
        end
    end

    assign open_ext  = {{OPEN_W{1'b0}}, open_sum};
    assign depth_ext = {{DEPTH_W{1'b0}}, depth_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, open_ext[OPEN_W-1:0], depth_ext[DEPTH_W-1:0],
                            status, skip_next};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            skipped_reg <= '0;
            skip_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                depth_reg   <= depth_next;
                skipped_reg <= skipped_next;
                skip_reg    <= skip_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_NEST; gi++) begin : g_cell
            logic up_v;
            logic down_v;
            if (gi == 0) begin : g_head
                assign up_v          = cell0_in;
                assign cell_ops[gi]  = op;
            end else begin : g_body
                assign up_v          = vals[gi-1];
                assign cell_ops[gi]  = '{push: op.push, pop: op.pop, load: 1'b0};
            end
            if (gi == MAX_NEST - 1) begin : g_tail
                assign down_v = 1'b0;
            end else begin : g_mid
                assign down_v = vals[gi+1];
            end
            cdnt_cell u_cell (
                .aclk     (aclk),
                .op       (cell_ops[gi]),
                .up_val   (up_v),
                .down_val (down_v),
                .val_out  (vals[gi])
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

[hw/rtl/cdnt_cell.sv]
// One entry of the condition value stack; shifts with its neighbors on push and pop, takes up_val on load.
`default_nettype none
module cdnt_cell
    import cdnt_pkg::*;
(
    input  wire logic     aclk,
    input  wire cell_op_t op,
    input  wire logic     up_val,
    input  wire logic     down_val,
    output logic          val_out
);

    logic val_reg;
    logic val_next;

    always_comb begin
        val_next = val_reg;
        if (op.push || op.load) begin
            val_next = up_val;
        end else if (op.pop) begin
            val_next = down_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val_out = val_reg;

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the conditional directive nesting tracker stream block.
`timescale 1ns / 1ps
module testbench;
    import cdnt_pkg::*;

    localparam int NEST_LIMIT = 30;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;
    localparam int PHASE_ITEMS = 200;
    localparam logic [2:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [2:0] REQ_UNUSED_MID = 3'd6;
    localparam logic [2:0] REQ_UNUSED_LAST = 3'd7;

    typedef struct packed {
        logic [2:0] req;
        logic       cond;
        logic       bad;
    } directive_t;

    typedef struct packed {
        logic       skip;
        status_t    status;
        logic [4:0] depth;
        logic [5:0] open;
    } outcome_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    directive_t pending_directives[$];
    outcome_t   expected_outcomes[$];
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    int         mismatches = 0;
    int         quiet_cycles = 0;
    int         opened_ifs = 0;

    // predictor state
    logic        cond_stack[NEST_LIMIT];
    int unsigned open_depth = 0;
    int unsigned skipped_levels = 0;
    logic        skipping = 1'b0;

    conditional_directive_nesting_tracker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic outcome_t track_directive(directive_t d);
        outcome_t o;
        o.status = ST_OK;
        o.open = '0;
        unique case (d.req)
            REQ_IF: begin
                if (skipping) begin
                    if (skipped_levels < NEST_LIMIT) skipped_levels++;
                    else o.status = ST_SKIP_OVERFLOW;
                end else if (d.bad) begin
                    o.status = ST_MALFORMED;
                end else if (open_depth >= NEST_LIMIT) begin
                    o.status = ST_TOO_DEEP;
                end else begin
                    cond_stack[open_depth] = d.cond;
                    open_depth++;
                    skipping = !d.cond;
                end
            end
            REQ_ELIF: begin
                if (open_depth == 0) begin
                    o.status = ST_LONE_ELIF;
                end else if (skipped_levels != 0) begin
                end else if (d.bad) begin
                    o.status = ST_MALFORMED;
                end else if (cond_stack[open_depth-1]) begin
                    skipping = 1'b1;
                end else begin
                    cond_stack[open_depth-1] = d.cond;
                    skipping = !d.cond;
                end
            end
            REQ_ELSE: begin
                if (open_depth == 0) begin
                    o.status = ST_LONE_ELSE;
                end else if (skipped_levels != 0) begin
                end else if (cond_stack[open_depth-1]) begin
                    skipping = 1'b1;
                end else begin
                    cond_stack[open_depth-1] = 1'b1;
                    skipping = 1'b0;
                end
            end
            REQ_ENDIF: begin
                if (skipped_levels != 0) begin
                    skipped_levels--;
                end else if (open_depth == 0) begin
                    o.status = ST_LONE_ENDIF;
                end else begin
                    skipping = 1'b0;
                    open_depth--;
                end
            end
            REQ_EOF: begin
                o.open = 6'(open_depth + skipped_levels);
                if (open_depth != 0) o.status = ST_OPEN_AT_END;
                open_depth = 0;
                skipped_levels = 0;
                skipping = 1'b0;
            end
            default: begin
            end
        endcase
        o.skip = skipping;
        o.depth = 5'(open_depth);
        return o;
    endfunction

    task automatic add_directive(input logic [2:0] req, input logic cond, input logic bad);
        directive_t d;
        d.req = req;
        d.cond = cond;
        d.bad = bad;
        pending_directives.push_back(d);
        if (req == REQ_IF) opened_ifs++;
        else if (req == REQ_ENDIF && opened_ifs > 0) opened_ifs--;
        else if (req == REQ_EOF) opened_ifs = 0;
    endtask

    // long run of ifs, mostly taken, to hit the depth and skip-counter bounds
    task automatic add_dive(input int count, input int false_pct);
        for (int i = 0; i < count; i++)
            add_directive(REQ_IF, $urandom_range(99) >= false_pct, 1'b0);
    endtask

    task automatic add_random_directives(input int count);
        int added;
        int r;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 3) begin
                r = $urandom_range(20, 36);
                add_dive(r, $urandom_range(1) ? 5 : 40);
                added += r;
                continue;
            end
            r = $urandom_range(99);
            if (r < 35)
                add_directive(REQ_IF, 1'($urandom_range(1)), $urandom_range(99) < 6);
            else if (r < 48)
                add_directive(REQ_ELIF, 1'($urandom_range(1)), $urandom_range(99) < 6);
            else if (r < 60)
                add_directive(REQ_ELSE, 1'($urandom_range(1)), $urandom_range(99) < 6);
            else if (r < 96) begin
                if (opened_ifs == 0 && $urandom_range(99) < 75)
                    add_directive(REQ_IF, 1'($urandom_range(1)), 1'b0);
                else
                    add_directive(REQ_ENDIF, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (r < 98)
                add_directive(REQ_EOF, 1'($urandom_range(1)), 1'($urandom_range(1)));
            else
                add_directive(3'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                              1'($urandom_range(1)), 1'($urandom_range(1)));
            added++;
        end
    endtask

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_directives.size() != 0 || s_tvalid || expected_outcomes.size() != 0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_directives.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                directive_t d;
                d = pending_directives.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= d.req;
                s_tdata <= {6'b0, d.bad, d.cond};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        directive_t d;
        m_tready <= $urandom_range(99) >= recv_stall_pct;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.skip = m_tdata[0];
                got.status = status_t'(m_tdata[3:1]);
                got.depth = m_tdata[8:4];
                got.open = m_tdata[14:9];
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: unexpected word skip=%0b st=%0d depth=%0d open=%0d",
                                 got.skip, got.status, got.depth, got.open);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got.skip !== want.skip || got.status !== want.status ||
                        got.depth !== want.depth || got.open !== want.open) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp skip=%0b st=%0d depth=%0d open=%0d, ",
                                      "got skip=%0b st=%0d depth=%0d open=%0d"},
                                     want.skip, want.status, want.depth, want.open,
                                     got.skip, got.status, got.depth, got.open);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                d.req = s_tuser;
                d.cond = s_tdata[0];
                d.bad = s_tdata[1];
                expected_outcomes.push_back(track_directive(d));
            end
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: lone directives, malformed, unused codes, branch selection
        add_directive(REQ_ELIF, 1'b1, 1'b0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_ENDIF, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b1, 1'b1);
        add_directive(REQ_UNUSED_FIRST, 1'b1, 1'b1);
        add_directive(REQ_UNUSED_LAST, 1'b0, 1'b1);
        add_directive(REQ_UNUSED_MID, 1'b1, 1'b0);
        add_directive(REQ_EOF, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b1, 1'b0);
        add_directive(REQ_ELIF, 1'b1, 1'b1);
        add_directive(REQ_ELIF, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b1, 1'b1);
        add_directive(REQ_ELIF, 1'b1, 1'b0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_ENDIF, 1'b0, 1'b0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_ENDIF, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b0, 1'b0);
        add_directive(REQ_ELIF, 1'b0, 1'b0);
        add_directive(REQ_ELIF, 1'b1, 1'b0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_ENDIF, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b0, 1'b0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_IF, 1'b0, 1'b0);
        add_directive(REQ_EOF, 1'b1, 1'b1);
        wait_drained();

        // full stack, then one more if
        add_dive(NEST_LIMIT + 1, 0);
        add_directive(REQ_ELSE, 1'b0, 1'b0);
        add_directive(REQ_EOF, 1'b0, 1'b0);
        // one below full, then a false if and a saturating skip counter
        add_dive(NEST_LIMIT - 1, 0);
        add_directive(REQ_IF, 1'b0, 1'b0);
        add_dive(NEST_LIMIT + 1, 0);
        add_directive(REQ_EOF, 1'b0, 1'b0);

        add_random_directives(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 68;
        recv_stall_pct = 0;
        add_random_directives(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 68;
        add_random_directives(PHASE_ITEMS);
        wait_drained();

        send_idle_pct = 10;
        recv_stall_pct = 10;
        add_random_directives(PHASE_ITEMS);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge aclk);
        if (expected_outcomes.size() != 0) mismatches++;
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
